// File: hw/rtl/sog_pkg.sv
// Shared types and constants for the speed outlier gate.
// Used by sog_front, sog_back, speed_outlier_gate and sog_checker; depends on nothing.
package sog_pkg;

  // Field and datapath widths, sized for the largest supported window of 15.
  localparam int SPEED_W    = 16;
  localparam int CNT_W      = 4;
  localparam int SUM_W      = 20;
  localparam int SQ_W       = 35;
  localparam int DIFF_W     = 21;
  localparam int DSQ_W      = 2 * DIFF_W;
  localparam int VAR_W      = 2 * SUM_W;
  localparam int K2_W       = 6;
  localparam int KV_W       = K2_W + VAR_W;
  localparam int LIMIT_W    = 15;
  localparam int VARC_W     = 30;
  localparam int SIGMA_W    = 3;
  localparam int MISS_W     = 4;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 30;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_FILLING    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PASSED     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DIR_REJECT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OUTLIER    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEARED    = 3'd4;

  // Command code that clears the window.
  localparam logic CMD_CLEAR = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE_LIMIT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VARIANCE_FLOOR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VARIANCE_CEILING = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIGMA_MULTIPLE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MISS_LIMIT       = 3'd5;

  // Configuration reset values.
  localparam logic [LIMIT_W-1:0] RST_SPEED_LIMIT      = 15'd11059;
  localparam logic [LIMIT_W-1:0] RST_REVERSE_LIMIT    = 15'd1638;
  localparam logic [VARC_W-1:0]  RST_VARIANCE_FLOOR   = 30'd167772;
  localparam logic [VARC_W-1:0]  RST_VARIANCE_CEILING = 30'd671089;
  localparam logic [SIGMA_W-1:0] RST_SIGMA_MULTIPLE   = 3'd3;
  localparam logic [MISS_W-1:0]  RST_MISS_LIMIT       = 4'd3;

  typedef struct packed {
    logic                      command;
    logic signed [SPEED_W-1:0] speed;
    logic                      direction_known;
    logic                      clockwise;
  } item_t;

  // Entry of the queue between the front and back parts.
  typedef struct packed {
    logic                      command;
    logic signed [SPEED_W-1:0] speed;
    logic                      dir_ok;
  } qitem_t;

  typedef struct packed {
    logic                accepted;
    logic [STATUS_W-1:0] status;
    logic                window_flushed;
    logic [CNT_W-1:0]    fill_count;
  } result_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] speed_limit;
    logic [LIMIT_W-1:0] reverse_limit;
    logic [VARC_W-1:0]  variance_floor;
    logic [VARC_W-1:0]  variance_ceiling;
    logic [SIGMA_W-1:0] sigma_multiple;
    logic [MISS_W-1:0]  miss_limit;
  } cfg_t;

endpackage

// File: hw/rtl/sog_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the sample window of the speed outlier gate.
module sog_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 15
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/sog_fifo.sv
// Small register-based FIFO with full and empty flags (DEPTH of 2 or more).
// Stand-alone; used for the work queue and the result queue.
module sog_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hw/rtl/sog_front.sv
// Front part: accepts transactions, applies the direction gate and queues them.
// Depends on sog_pkg and sog_fifo.
module sog_front #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sog_pkg::item_t  item,
  output logic            full,
  input  sog_pkg::cfg_t   cfg,
  output sog_pkg::qitem_t head,
  output logic            head_valid,
  input  logic            head_pop
);

  localparam int GW = sog_pkg::SPEED_W + 1;

  logic signed [GW-1:0] v_ext;
  logic signed [GW-1:0] lim;
  logic signed [GW-1:0] rev;
  logic                 dir_ok;
  sog_pkg::qitem_t      entry;
  logic                 empty;

  assign v_ext = GW'(item.speed);
  assign lim   = $signed(GW'(cfg.speed_limit));
  assign rev   = $signed(GW'(cfg.reverse_limit));

  // Unknown direction bounds the magnitude; a known direction allows only a
  // small excursion against it.
  always_comb begin
    if (!item.direction_known) begin
      dir_ok = !((v_ext > lim) || (v_ext < -lim));
    end else if (item.clockwise) begin
      dir_ok = !((v_ext > lim) || (v_ext < -rev));
    end else begin
      dir_ok = !((v_ext < -lim) || (v_ext > rev));
    end
  end

  always_comb begin
    entry.command = item.command;
    entry.speed   = item.speed;
    entry.dir_ok  = dir_ok;
  end

  sog_fifo #(
    .WIDTH ($bits(sog_pkg::qitem_t)),
    .DEPTH (DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (entry),
    .full  (full),
    .pop   (head_pop),
    .rdata (head),
    .empty (empty)
  );

  assign head_valid = !empty;

endmodule

// File: hw/rtl/sog_back.sv
// Back part: holds the window state and judges each queued transaction.
// Depends on sog_pkg and sog_ram.
module sog_back #(
  parameter int WINDOW = 15
) (
  input  logic             clk,
  input  logic             rst,
  input  sog_pkg::qitem_t  head,
  input  logic             head_valid,
  output logic             head_pop,
  input  sog_pkg::cfg_t    cfg,
  output sog_pkg::result_t res,
  output logic             res_push,
  input  logic             res_full
);

  localparam int AW  = $clog2(WINDOW);
  localparam int WSQ = WINDOW * WINDOW;
  localparam int SW  = sog_pkg::SPEED_W;

  localparam logic [1:0] PH_ISSUE  = 2'd0;
  localparam logic [1:0] PH_SPREAD = 2'd1;
  localparam logic [1:0] PH_DECIDE = 2'd2;

  logic [1:0] phase, phase_next;

  logic [sog_pkg::CNT_W-1:0]         held_count, held_count_next;
  logic [AW-1:0]                     oldest_pointer, oldest_pointer_next;
  logic signed [sog_pkg::SUM_W-1:0]  running_sum, running_sum_next;
  logic [sog_pkg::SQ_W-1:0]          running_square_sum, running_square_sum_next;
  logic [sog_pkg::MISS_W-1:0]        miss_count, miss_count_next;

  // Judgement pipeline registers.
  logic [sog_pkg::VAR_W-1:0]         sum_sq;
  logic [sog_pkg::VAR_W-1:0]         scaled_sq_sum;
  logic signed [sog_pkg::DIFF_W-1:0] diff;
  logic [sog_pkg::VAR_W-1:0]         var_clamp;
  logic [sog_pkg::DSQ_W-1:0]         diff_sq;
  logic [2*SW-1:0]                   new_sq;
  logic [2*SW-1:0]                   old_sq;
  logic [sog_pkg::VAR_W-1:0]         var_lo;
  logic [sog_pkg::VAR_W-1:0]         var_hi;
  logic [sog_pkg::K2_W-1:0]          k_sq;

  logic signed [SW-1:0]                v;
  logic signed [SW-1:0]                old_v;
  logic signed [2*SW-1:0]              v_sq;
  logic signed [2*SW-1:0]              old_v_sq;
  logic signed [sog_pkg::VAR_W-1:0]    s_sq;
  logic signed [sog_pkg::DIFF_W-1:0]   diff_now;
  logic signed [sog_pkg::DSQ_W-1:0]    diff_sq_now;
  logic signed [sog_pkg::VAR_W-1:0]    var_raw;
  logic [sog_pkg::VAR_W-1:0]           var_clamp_now;
  logic [sog_pkg::KV_W-1:0]            kv;
  logic                                outlier;
  logic [sog_pkg::MISS_W:0]            miss_inc;
  logic                                miss_flush;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_re;
  logic [SW-1:0] ram_rdata;

  logic done;
  logic miss_event;
  logic clear_event;

  assign v        = head.speed;
  assign old_v    = $signed(ram_rdata);
  assign v_sq     = v * v;
  assign old_v_sq = old_v * old_v;
  assign s_sq     = running_sum * running_sum;
  assign diff_now = sog_pkg::DIFF_W'(v) * sog_pkg::DIFF_W'(WINDOW)
                    - sog_pkg::DIFF_W'(running_sum);
  assign diff_sq_now = diff * diff;

  // W*Q - S*S is W*W times the window variance.
  assign var_raw = $signed(scaled_sq_sum) - $signed(sum_sq);

  // Floor first, then ceiling, so the ceiling wins if the two cross.
  always_comb begin
    if (var_raw < $signed(var_lo)) begin
      var_clamp_now = var_lo;
    end else begin
      var_clamp_now = var_raw;
    end
    if ($signed(var_clamp_now) > $signed(var_hi)) begin
      var_clamp_now = var_hi;
    end
  end

  assign kv         = sog_pkg::KV_W'(k_sq) * sog_pkg::KV_W'(var_clamp);
  assign outlier    = sog_pkg::KV_W'(diff_sq) > kv;
  assign miss_inc   = {1'b0, miss_count} + (sog_pkg::MISS_W + 1)'(1);
  assign miss_flush = miss_inc > {1'b0, cfg.miss_limit};

  always_comb begin
    phase_next              = phase;
    held_count_next         = held_count;
    oldest_pointer_next     = oldest_pointer;
    running_sum_next        = running_sum;
    running_square_sum_next = running_square_sum;
    miss_count_next         = miss_count;
    ram_we                  = 1'b0;
    ram_waddr               = oldest_pointer;
    ram_re                  = 1'b0;
    done                    = 1'b0;
    miss_event              = 1'b0;
    clear_event             = 1'b0;
    res.accepted            = 1'b0;
    res.status              = sog_pkg::ST_FILLING;
    res.window_flushed      = 1'b0;
    res.fill_count          = held_count;

    case (phase)
      PH_ISSUE: begin
        if (head_valid) begin
          if (head.command == sog_pkg::CMD_CLEAR) begin
            if (!res_full) begin
              done        = 1'b1;
              clear_event = 1'b1;
              res.status  = sog_pkg::ST_CLEARED;
            end
          end else if (!head.dir_ok) begin
            if (!res_full) begin
              done       = 1'b1;
              miss_event = 1'b1;
              res.status = sog_pkg::ST_DIR_REJECT;
            end
          end else if (held_count < sog_pkg::CNT_W'(WINDOW)) begin
            if (!res_full) begin
              done                    = 1'b1;
              ram_we                  = 1'b1;
              ram_waddr               = held_count[AW-1:0];
              held_count_next         = held_count + sog_pkg::CNT_W'(1);
              running_sum_next        = running_sum + sog_pkg::SUM_W'(v);
              running_square_sum_next = running_square_sum + sog_pkg::SQ_W'(v_sq);
              miss_count_next         = '0;
              res.accepted            = 1'b1;
              res.status              = sog_pkg::ST_FILLING;
              res.fill_count          = held_count + sog_pkg::CNT_W'(1);
            end
          end else begin
            // Full window: fetch the oldest sample and start the test.
            ram_re     = 1'b1;
            phase_next = PH_SPREAD;
          end
        end
      end
      PH_SPREAD: begin
        phase_next = PH_DECIDE;
      end
      PH_DECIDE: begin
        if (!res_full) begin
          done       = 1'b1;
          phase_next = PH_ISSUE;
          if (outlier) begin
            miss_event = 1'b1;
            res.status = sog_pkg::ST_OUTLIER;
          end else begin
            ram_we                  = 1'b1;
            running_sum_next        = running_sum + sog_pkg::SUM_W'(v)
                                      - sog_pkg::SUM_W'(old_v);
            running_square_sum_next = running_square_sum + sog_pkg::SQ_W'(new_sq)
                                      - sog_pkg::SQ_W'(old_sq);
            oldest_pointer_next     = (oldest_pointer == AW'(WINDOW - 1)) ?
                                      '0 : oldest_pointer + AW'(1);
            miss_count_next         = '0;
            res.accepted            = 1'b1;
            res.status              = sog_pkg::ST_PASSED;
          end
        end
      end
      default: begin
        phase_next = PH_ISSUE;
      end
    endcase

    if (miss_event) begin
      if (miss_flush) begin
        clear_event = 1'b1;
      end else begin
        miss_count_next = miss_inc[sog_pkg::MISS_W-1:0];
      end
    end

    if (clear_event) begin
      held_count_next         = '0;
      oldest_pointer_next     = '0;
      running_sum_next        = '0;
      running_square_sum_next = '0;
      miss_count_next         = '0;
      res.window_flushed      = 1'b1;
      res.fill_count          = '0;
    end
  end

  assign head_pop = done;
  assign res_push = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_ISSUE;
      held_count         <= '0;
      oldest_pointer     <= '0;
      running_sum        <= '0;
      running_square_sum <= '0;
      miss_count         <= '0;
    end else begin
      phase              <= phase_next;
      held_count         <= held_count_next;
      oldest_pointer     <= oldest_pointer_next;
      running_sum        <= running_sum_next;
      running_square_sum <= running_square_sum_next;
      miss_count         <= miss_count_next;
    end
  end

  // Every input of these stages is stable while an item is under test, so
  // they simply load each cycle.
  always_ff @(posedge clk) begin
    sum_sq        <= s_sq;
    scaled_sq_sum <= sog_pkg::VAR_W'(running_square_sum) * sog_pkg::VAR_W'(WINDOW);
    diff          <= diff_now;
    var_clamp     <= var_clamp_now;
    diff_sq       <= diff_sq_now;
    new_sq        <= v_sq;
    old_sq        <= old_v_sq;
    var_lo        <= sog_pkg::VAR_W'(cfg.variance_floor) * sog_pkg::VAR_W'(WSQ);
    var_hi        <= sog_pkg::VAR_W'(cfg.variance_ceiling) * sog_pkg::VAR_W'(WSQ);
    k_sq          <= sog_pkg::K2_W'(cfg.sigma_multiple) * sog_pkg::K2_W'(cfg.sigma_multiple);
  end

  sog_ram #(
    .WIDTH (SW),
    .DEPTH (WINDOW)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (head.speed),
    .re    (ram_re),
    .raddr (oldest_pointer),
    .rdata (ram_rdata)
  );

endmodule

// File: hw/rtl/speed_outlier_gate.sv
// Throughput: one transaction per cycle for clears, direction rejects and samples that
// fill the window, while the result queue has room; a sample judged against a full
// window passes the square, clamp and compare stages before the next one is taken.
// Reset (rst, synchronous) empties both queues, the window state and the miss count
// and restores the configuration registers to defaults; window contents stay
// undefined until written.
module speed_outlier_gate #(
  parameter int WINDOW       = 15,
  parameter int ITEM_DEPTH   = 4,
  parameter int RESULT_DEPTH = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  // Input side, queue style.
  input  logic                             push,
  input  sog_pkg::item_t                   item,
  output logic                             full,
  // Result side, queue style.
  output logic                             empty,
  input  logic                             pop,
  output sog_pkg::result_t                 result,
  // Configuration writes.
  input  logic                             cfg_write,
  input  logic [sog_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sog_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // Configuration registers. The user must make writes land only while the block is idle;
  // the block does not enforce it. Both parts read them directly without any handover.
  sog_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.speed_limit      <= sog_pkg::RST_SPEED_LIMIT;
      cfg.reverse_limit    <= sog_pkg::RST_REVERSE_LIMIT;
      cfg.variance_floor   <= sog_pkg::RST_VARIANCE_FLOOR;
      cfg.variance_ceiling <= sog_pkg::RST_VARIANCE_CEILING;
      cfg.sigma_multiple   <= sog_pkg::RST_SIGMA_MULTIPLE;
      cfg.miss_limit       <= sog_pkg::RST_MISS_LIMIT;
    end else if (cfg_write) begin
      case (cfg_index)
        sog_pkg::REG_SPEED_LIMIT:
          cfg.speed_limit <= cfg_data[sog_pkg::LIMIT_W-1:0];
        sog_pkg::REG_REVERSE_LIMIT:
          cfg.reverse_limit <= cfg_data[sog_pkg::LIMIT_W-1:0];
        sog_pkg::REG_VARIANCE_FLOOR:
          cfg.variance_floor <= cfg_data[sog_pkg::VARC_W-1:0];
        sog_pkg::REG_VARIANCE_CEILING:
          cfg.variance_ceiling <= cfg_data[sog_pkg::VARC_W-1:0];
        sog_pkg::REG_SIGMA_MULTIPLE:
          cfg.sigma_multiple <= cfg_data[sog_pkg::SIGMA_W-1:0];
        sog_pkg::REG_MISS_LIMIT:
          cfg.miss_limit <= cfg_data[sog_pkg::MISS_W-1:0];
        default: begin
          // Indexes past the last register are ignored.
        end
      endcase
    end
  end

  // The front part gates each transaction on its direction limits as it is
  // pushed and queues it with the verdict. The queue lets the front keep
  // taking transactions while the back part is busy with a full-window judgement.
  sog_pkg::qitem_t head;
  logic            head_valid;
  logic            head_pop;

  sog_front #(
    .DEPTH (ITEM_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .item       (item),
    .full       (full),
    .cfg        (cfg),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop)
  );

  // The back part owns the window, the running sums and the miss count. It
  // retires clears, direction rejects and filling samples in its issue state,
  // and runs the sigma test on a full window as sum square and scaled square
  // sum, then clamped variance and squared distance, then the final product,
  // compare and state update.
  sog_pkg::result_t res;
  logic             res_push;
  logic             res_full;

  sog_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .cfg        (cfg),
    .res        (res),
    .res_push   (res_push),
    .res_full   (res_full)
  );

  // Result queue: finished results wait here, so a stalled consumer does
  // not stop the back part until this queue fills.
  sog_fifo #(
    .WIDTH ($bits(sog_pkg::result_t)),
    .DEPTH (RESULT_DEPTH)
  ) u_results (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

endmodule

// File: hw/rtl/sog_checker.sv
// Port-level checks for speed_outlier_gate, attached with a bind statement.
// Depends on sog_pkg and speed_outlier_gate.
module sog_checker (
  input logic             clk,
  input logic             rst,
  input logic             empty,
  input logic             pop,
  input sog_pkg::result_t result
);

  // Nothing is waiting right after reset.
  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result waiting right after reset");

  // A waiting result that is not taken stays unchanged.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed or vanished");

  // A clear always reports an empty window and no stored sample.
  a_clear_shape: assert property (@(posedge clk) disable iff (rst)
    (!empty && (result.status == sog_pkg::ST_CLEARED)) |->
      (result.window_flushed && (result.fill_count == '0) && !result.accepted))
    else $error("clear result malformed");

  // Only filling or passing samples are stored, and they never flush.
  a_accept_shape: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.accepted) |->
      (((result.status == sog_pkg::ST_FILLING) || (result.status == sog_pkg::ST_PASSED))
       && !result.window_flushed && (result.fill_count != '0)))
    else $error("accepted result malformed");

  // A flush leaves an empty window.
  a_flush_empties: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.window_flushed) |-> (result.fill_count == '0))
    else $error("flushed result shows samples held");

endmodule

bind speed_outlier_gate sog_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

// File: tb/tb_speed_outlier_gate.sv
`timescale 1ns / 100ps
// Self-checking testbench for speed_outlier_gate: directed and random sample streams are
// judged by an in-bench window model, and every popped result is compared with its verdict.
// Depends on sog_pkg and the speed_outlier_gate RTL only.
module tb_speed_outlier_gate;

  localparam int WIN         = 15;
  localparam int IDLE_PCT    = 22;
  localparam int HOLD_CYCLES = 300;
  localparam int PRINT_CAP   = 200;

  // A judged sample is the opposite of the clear command.
  localparam logic CMD_JUDGE = ~sog_pkg::CMD_CLEAR;

  // Indexes beyond the last register; writes there must change nothing.
  localparam logic [sog_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [sog_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // Every input of the block is at a known value from time zero.
  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           push      = 1'b0;
  logic                           pop       = 1'b0;
  logic                           cfg_write = 1'b0;
  logic [sog_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [sog_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
  sog_pkg::item_t                 item      = '0;
  logic                           full;
  logic                           empty;
  sog_pkg::result_t               result;

  speed_outlier_gate #(.WINDOW(WIN)) uut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Samples waiting to be offered, and verdicts waiting for their result transaction.
  sog_pkg::item_t   offered_items[$];
  sog_pkg::result_t expected_verdicts[$];

  int mismatches       = 0;
  int verdicts_checked = 0;

  // When calm is set, neither side idles; this gives back-to-back traffic stretches.
  logic calm = 1'b0;

  // The stimulus process asks for a long result hold-off by bumping hold_asks; the
  // counter process below notices the change, loads hold_left with HOLD_CYCLES and keeps pop low until it reaches zero.
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // Mirror of the configuration registers, at their reset values.
  int     speed_lim = int'(sog_pkg::RST_SPEED_LIMIT);
  int     rev_lim   = int'(sog_pkg::RST_REVERSE_LIMIT);
  longint var_floor = longint'(sog_pkg::RST_VARIANCE_FLOOR);
  longint var_ceil  = longint'(sog_pkg::RST_VARIANCE_CEILING);
  int     sigma_k   = int'(sog_pkg::RST_SIGMA_MULTIPLE);
  int     miss_lim  = int'(sog_pkg::RST_MISS_LIMIT);

  // Mirror of the window. Entries are only read once the window is full, so every
  // entry read has been written since the last flush.
  longint win_buf [WIN];
  int     win_oldest = 0;
  int     win_held   = 0;
  longint win_sum    = 0;
  longint win_sqsum  = 0;
  int     miss_run   = 0;

  task automatic report_mismatch(string what, longint got, longint want);
    if (mismatches < PRINT_CAP)
      $display("mismatch at verdict %0d: %s got %0d, expected %0d",
               verdicts_checked, what, got, want);
    mismatches++;
  endtask

  function automatic void flush_window();
    win_held   = 0;
    win_oldest = 0;
    win_sum    = 0;
    win_sqsum  = 0;
  endfunction

  // Counts one rejection; returns 1 when it pushes the run past the limit and the
  // window is emptied, even if it was already empty.
  function automatic logic note_miss();
    int next_run;
    next_run = miss_run + 1;
    if (next_run > miss_lim) begin
      miss_run = 0;
      flush_window();
      return 1'b1;
    end
    miss_run = next_run & 15;
    return 1'b0;
  endfunction

  // Works out the verdict for one accepted transaction and advances the window mirror.
  function automatic sog_pkg::result_t judge_sample(sog_pkg::item_t it);
    sog_pkg::result_t r;
    longint  v;
    longint  spread;
    longint  lo;
    longint  hi;
    longint  d;
    longint  k;
    longint  old;
    logic    dir_pass;
    r = '0;
    v = longint'($signed(it.speed));
    if (it.command == sog_pkg::CMD_CLEAR) begin
      flush_window();
      miss_run = 0;
      r.status = sog_pkg::ST_CLEARED;
      r.window_flushed = 1'b1;
    end else begin
      // Direction gate: the forward limit applies both ways when the direction is
      // unknown; with a known direction, the backward side gets the reverse limit.
      if (!it.direction_known)
        dir_pass = (v <= speed_lim) && (v >= -speed_lim);
      else if (it.clockwise)
        dir_pass = (v <= speed_lim) && (v >= -rev_lim);
      else
        dir_pass = (v >= -speed_lim) && (v <= rev_lim);

      if (!dir_pass) begin
        r.status = sog_pkg::ST_DIR_REJECT;
        r.window_flushed = note_miss();
      end else if (win_held < WIN) begin
        win_buf[win_held] = v;
        win_held++;
        win_sum   += v;
        win_sqsum += v * v;
        miss_run   = 0;
        r.accepted = 1'b1;
        r.status   = sog_pkg::ST_FILLING;
      end else begin
        // Exact 3-sigma style test, scaled by W*W so that nothing is divided.
        // The floor clamp goes first, so the ceiling wins when the two cross.
        spread = win_sqsum * WIN - win_sum * win_sum;
        lo = var_floor * WIN * WIN;
        hi = var_ceil * WIN * WIN;
        if (spread < lo) spread = lo;
        if (spread > hi) spread = hi;
        d = WIN * v - win_sum;
        k = sigma_k;
        if (d * d > k * k * spread) begin
          r.status = sog_pkg::ST_OUTLIER;
          r.window_flushed = note_miss();
        end else begin
          old = win_buf[win_oldest];
          win_sum   += v - old;
          win_sqsum += v * v - old * old;
          win_buf[win_oldest] = v;
          win_oldest = (win_oldest + 1) % WIN;
          miss_run   = 0;
          r.accepted = 1'b1;
          r.status   = sog_pkg::ST_PASSED;
        end
      end
    end
    r.fill_count = sog_pkg::CNT_W'(win_held);
    return r;
  endfunction

  // Sender: offers the oldest pending sample at the falling edge, idling at random
  // unless a calm stretch is running. An offer may be withdrawn while full is high.
  always @(negedge clk) begin : sample_driver
    if (offered_items.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
      push <= 1'b1;
      item <= offered_items[0];
    end else begin
      push <= 1'b0;
    end
  end

  // A transaction is taken at the rising edge with push high and full low; the
  // verdict is computed right here, against the configuration in force.
  always @(posedge clk) begin : sample_accept
    if (!rst && push && !full) begin
      expected_verdicts = {expected_verdicts, judge_sample(item)};
      offered_items.delete(0);
    end
  end

  always @(posedge clk) begin : hold_counter
    if (hold_asks != hold_seen) begin
      hold_seen <= hold_asks;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: stalls at random, and for the whole of a requested hold-off.
  always @(negedge clk) begin : verdict_drain
    pop <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= IDLE_PCT);
  end

  // Checker: each popped result is matched against the oldest waiting verdict.
  always @(posedge clk) begin : verdict_check
    sog_pkg::result_t want;
    if (!rst && pop && !empty) begin
      if (expected_verdicts.size() == 0) begin
        report_mismatch("result with no verdict waiting, raw", longint'(result), 0);
      end else begin
        want = expected_verdicts.pop_front();
        if (result.accepted != want.accepted)
          report_mismatch("accepted", result.accepted, want.accepted);
        if (result.status != want.status)
          report_mismatch("status", result.status, want.status);
        if (result.window_flushed != want.window_flushed)
          report_mismatch("window_flushed", result.window_flushed, want.window_flushed);
        if (result.fill_count != want.fill_count)
          report_mismatch("fill_count", result.fill_count, want.fill_count);
      end
      verdicts_checked++;
    end
  end

  // Queues one transaction; speeds outside the 16-bit range are saturated.
  task automatic offer(logic cmd, int spd, logic known, logic cw);
    sog_pkg::item_t it;
    if (spd > 32767) spd = 32767;
    if (spd < -32768) spd = -32768;
    it.command         = cmd;
    it.speed           = sog_pkg::SPEED_W'(spd);
    it.direction_known = known;
    it.clockwise       = cw;
    offered_items = {offered_items, it};
  endtask

  // Register write while the block is idle; the mirror follows the same masking.
  task automatic write_reg(logic [sog_pkg::CFG_IDX_W-1:0] idx,
                           logic [sog_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      sog_pkg::REG_SPEED_LIMIT:      speed_lim = int'(data[sog_pkg::LIMIT_W-1:0]);
      sog_pkg::REG_REVERSE_LIMIT:    rev_lim   = int'(data[sog_pkg::LIMIT_W-1:0]);
      sog_pkg::REG_VARIANCE_FLOOR:   var_floor = longint'(data[sog_pkg::VARC_W-1:0]);
      sog_pkg::REG_VARIANCE_CEILING: var_ceil  = longint'(data[sog_pkg::VARC_W-1:0]);
      sog_pkg::REG_SIGMA_MULTIPLE:   sigma_k   = int'(data[sog_pkg::SIGMA_W-1:0]);
      sog_pkg::REG_MISS_LIMIT:       miss_lim  = int'(data[sog_pkg::MISS_W-1:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Waits until every sample has been taken and every verdict checked, then lets
  // the pipeline run dry.
  task automatic settle();
    while (offered_items.size() != 0 || expected_verdicts.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Random traffic shaped like a real sensor stream: bursts of samples scattered
  // around a mean that respects the forward limit, long enough to fill the window and
  // then be judged against it, salted with far-off samples, raw noise and clears.
  task automatic offer_stream(int count);
    int   left;
    int   lim;
    int   mean;
    int   spread;
    int   run;
    int   pick;
    int   v;
    logic known;
    left = count;
    while (left > 0) begin
      lim    = (speed_lim > 9000) ? 9000 : speed_lim;
      mean   = int'($urandom_range(0, 2 * lim)) - lim;
      spread = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 700));
      known  = ($urandom_range(0, 9) < 3);
      run    = WIN + int'($urandom_range(5, 30));
      if ($urandom_range(0, 19) == 0) begin
        offer(sog_pkg::CMD_CLEAR, int'($urandom_range(0, 65535)) - 32768,
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        left--;
      end
      for (int i = 0; i < run && left > 0; i++) begin
        pick = int'($urandom_range(0, 99));
        if (pick < 8) begin
          offer(CMD_JUDGE, int'($urandom_range(0, 65535)) - 32768,
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else if (pick < 16) begin
          v = 1500 + int'($urandom_range(0, 8000));
          offer(CMD_JUDGE, ($urandom_range(0, 1) != 0) ? mean + v : mean - v,
                known, mean >= 0);
        end else begin
          offer(CMD_JUDGE, mean + int'($urandom_range(0, 2 * spread)) - spread,
                known, mean >= 0);
        end
        left--;
      end
    end
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset configuration. A clear whose other fields are junk.
    offer(sog_pkg::CMD_CLEAR, -32768, 1'b1, 1'b1);
    // Unknown direction: the limit itself passes, one past it on either side fails,
    // and so do both ends of the range. The fourth miss in a row flushes the window.
    offer(CMD_JUDGE, int'(sog_pkg::RST_SPEED_LIMIT), 1'b0, 1'b0);
    offer(CMD_JUDGE, int'(sog_pkg::RST_SPEED_LIMIT) + 1, 1'b0, 1'b1);
    offer(CMD_JUDGE, -int'(sog_pkg::RST_SPEED_LIMIT) - 1, 1'b0, 1'b0);
    offer(CMD_JUDGE, 32767, 1'b0, 1'b0);
    offer(CMD_JUDGE, -32768, 1'b0, 1'b1);
    // Clockwise: reverse limit on the negative side, forward limit on the positive.
    offer(CMD_JUDGE, -int'(sog_pkg::RST_REVERSE_LIMIT), 1'b1, 1'b1);
    offer(CMD_JUDGE, -int'(sog_pkg::RST_REVERSE_LIMIT) - 1, 1'b1, 1'b1);
    offer(CMD_JUDGE, int'(sog_pkg::RST_SPEED_LIMIT), 1'b1, 1'b1);
    offer(CMD_JUDGE, int'(sog_pkg::RST_SPEED_LIMIT) + 1, 1'b1, 1'b1);
    // Counter-clockwise is the mirror image.
    offer(CMD_JUDGE, int'(sog_pkg::RST_REVERSE_LIMIT), 1'b1, 1'b0);
    offer(CMD_JUDGE, int'(sog_pkg::RST_REVERSE_LIMIT) + 1, 1'b1, 1'b0);
    offer(CMD_JUDGE, -int'(sog_pkg::RST_SPEED_LIMIT), 1'b1, 1'b0);
    offer(CMD_JUDGE, -int'(sog_pkg::RST_SPEED_LIMIT) - 1, 1'b1, 1'b0);
    // Clear, then enough misses to flush a window that is already empty.
    offer(sog_pkg::CMD_CLEAR, 0, 1'b0, 1'b0);
    offer(CMD_JUDGE, 32767, 1'b0, 1'b0);
    offer(CMD_JUDGE, -32768, 1'b0, 1'b0);
    offer(CMD_JUDGE, 20000, 1'b1, 1'b0);
    offer(CMD_JUDGE, -int'(sog_pkg::RST_REVERSE_LIMIT) - 1, 1'b1, 1'b1);
    offer_stream(200);
    settle();

    // Widest settings, plus writes to the unused indexes. The receiver holds off for
    // a long stretch at the start so both internal queues fill and full rises.
    write_reg(sog_pkg::REG_SPEED_LIMIT, 30'd32767);
    write_reg(sog_pkg::REG_REVERSE_LIMIT, 30'd32767);
    write_reg(sog_pkg::REG_VARIANCE_FLOOR, 30'd0);
    write_reg(sog_pkg::REG_VARIANCE_CEILING, 30'h3FFF_FFFF);
    write_reg(sog_pkg::REG_SIGMA_MULTIPLE, 30'd7);
    write_reg(sog_pkg::REG_MISS_LIMIT, 30'd15);
    write_reg(REG_SPARE_LO, sog_pkg::CFG_DATA_W'($urandom));
    write_reg(REG_SPARE_HI, sog_pkg::CFG_DATA_W'($urandom));
    hold_asks++;
    offer_stream(200);
    settle();

    // Narrowest settings: only a zero speed gets through the gate, any miss flushes.
    write_reg(sog_pkg::REG_SPEED_LIMIT, 30'd0);
    write_reg(sog_pkg::REG_REVERSE_LIMIT, 30'd0);
    write_reg(sog_pkg::REG_VARIANCE_FLOOR, 30'd0);
    write_reg(sog_pkg::REG_VARIANCE_CEILING, 30'd0);
    write_reg(sog_pkg::REG_SIGMA_MULTIPLE, 30'd0);
    write_reg(sog_pkg::REG_MISS_LIMIT, 30'd0);
    offer_stream(60);
    settle();

    // Same zero sigma with an open gate: a full window of equal samples accepts an
    // equal sample and rejects anything else.
    write_reg(sog_pkg::REG_SPEED_LIMIT, 30'd4096);
    for (int i = 0; i <= WIN; i++)
      offer(CMD_JUDGE, 0, 1'b0, 1'b0);
    offer(CMD_JUDGE, 1, 1'b0, 1'b0);
    offer_stream(54);
    settle();

    // Floor above ceiling, so the ceiling decides; no idling on either side.
    write_reg(sog_pkg::REG_SPEED_LIMIT, 30'd20000);
    write_reg(sog_pkg::REG_REVERSE_LIMIT, 30'd500);
    write_reg(sog_pkg::REG_VARIANCE_FLOOR, 30'd2684356);
    write_reg(sog_pkg::REG_VARIANCE_CEILING, 30'd167772);
    write_reg(sog_pkg::REG_SIGMA_MULTIPLE, 30'd2);
    write_reg(sog_pkg::REG_MISS_LIMIT, 30'd1);
    calm = 1'b1;
    offer_stream(200);
    settle();
    calm = 1'b0;

    // A random setting in the range where the clamps and the test both matter.
    write_reg(sog_pkg::REG_SPEED_LIMIT, sog_pkg::CFG_DATA_W'($urandom_range(0, 32767)));
    write_reg(sog_pkg::REG_REVERSE_LIMIT, sog_pkg::CFG_DATA_W'($urandom_range(0, 32767)));
    write_reg(sog_pkg::REG_VARIANCE_FLOOR,
              sog_pkg::CFG_DATA_W'($urandom_range(0, 2000000)));
    write_reg(sog_pkg::REG_VARIANCE_CEILING,
              sog_pkg::CFG_DATA_W'($urandom_range(0, 4000000)));
    write_reg(sog_pkg::REG_SIGMA_MULTIPLE, sog_pkg::CFG_DATA_W'($urandom_range(1, 7)));
    write_reg(sog_pkg::REG_MISS_LIMIT, sog_pkg::CFG_DATA_W'($urandom_range(0, 15)));
    offer_stream(200);
    settle();

    if (mismatches == 0)
      $display("tb_speed_outlier_gate: PASS");
    else
      $display("tb_speed_outlier_gate: FAIL");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, including the long hold-off.
  initial begin : watchdog
    #4000000;
    $display("tb_speed_outlier_gate: FAIL");
    $finish;
  end

endmodule
